// ----- hdl/binary_to_decimal_ascii_unit_macros.svh -----
// Assertion macros shared by the binary to decimal ASCII unit.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BDAU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BDAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bdau_pkg.sv -----
// Types and constants of the binary to decimal ASCII unit.
package bdau_pkg;

  localparam int IN_WIDTH   = 32;
  localparam int MAX_DIGITS = 10;
  localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int CHAR_W     = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit_step;
  } dp_cmd_t;

  typedef struct packed {
    logic bits_done;
    logic digits_done;
  } dp_stat_t;

endpackage

// ----- hdl/bdau_ctrl.sv -----
// Sequencer of the binary to decimal ASCII unit: load, convert, emit.
module bdau_ctrl
  import bdau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd.shift = 1'b1;
        if (stat.bits_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        if (stat.digits_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/bdau_dpath.sv -----
// Datapath: serial double-dabble converter and digit emitter.
module bdau_dpath
  import bdau_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IN_WIDTH-1:0] value,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic                strobe,
  output logic [CHAR_W-1:0]   digit_char,
  output logic                last
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] operand;
  logic [VALUE_WIDTH-1:0] bin;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       bit_cnt;
  logic [DIG_CNT_W-1:0]   dig_cnt;
  logic                   started;
  logic [3:0]             top_digit;
  logic                   top_nz;
  logic                   final_digit;

  // Only the low VALUE_WIDTH bits of the input count
  if (VALUE_WIDTH <= IN_WIDTH) begin : g_trunc
    assign operand = value[VALUE_WIDTH-1:0];
  end else begin : g_ext
    assign operand = {{(VALUE_WIDTH - IN_WIDTH){1'b0}}, value};
  end

  // add-3 on every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3 : bcd[4*d +: 4];
    end
  end

  assign top_digit   = bcd[BCD_W-1 -: 4];
  assign top_nz      = (top_digit != 4'd0);
  assign final_digit = (dig_cnt == DIG_CNT_W'(1));

  assign stat.bits_done   = (bit_cnt == '0);
  assign stat.digits_done = final_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe  <= 1'b0;
      bit_cnt <= '0;
      dig_cnt <= '0;
      started <= 1'b0;
    end else begin
      strobe <= cmd.emit_step & (started | top_nz | final_digit);
      if (cmd.load) begin
        bit_cnt <= CNT_W'(VALUE_WIDTH - 1);
        dig_cnt <= DIG_CNT_W'(MAX_DIGITS);
        started <= 1'b0;
      end else if (cmd.shift) begin
        bit_cnt <= bit_cnt - CNT_W'(1);
      end else if (cmd.emit_step) begin
        dig_cnt <= dig_cnt - DIG_CNT_W'(1);
        started <= started | top_nz;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= operand;
      bcd <= '0;
    end else if (cmd.shift) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_WIDTH-1]};
      bin <= {bin[VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd.emit_step) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
    end
    if (cmd.emit_step) begin
      digit_char <= {2'b00, top_digit} + ASCII_ZERO;
      last       <= final_digit;
    end
  end

endmodule

// ----- hdl/binary_to_decimal_ascii_unit.sv -----
// Top level of the binary to decimal ASCII unit.
//
// Converts one unsigned number to decimal ASCII text, most significant digit
// first, leading zeros suppressed (zero gives a single '0'). An input word is
// taken on a clock edge with start high and busy low. Each digit comes out
// for exactly one cycle with strobe high; the receiver cannot stall, so it
// must take every digit on the cycle it appears. The final digit of each
// number has last set. Each word passes through a load step, then the
// serial double-dabble shifter (one input bit per cycle), then a digit
// scan over all ten BCD digits that skips leading zeros and emits the rest,
// one digit per cycle. The busy output drops on the cycle the final digit
// is presented, so the next word may start while that digit is on the ports.
// Only the ten least significant decimal digits are kept; as the input port
// has IN_WIDTH (32) bits and is zero-extended, every input value fits.
`include "binary_to_decimal_ascii_unit_macros.svh"

module binary_to_decimal_ascii_unit
  import bdau_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [IN_WIDTH-1:0] value,
  output logic                strobe,
  output logic [CHAR_W-1:0]   digit_char,
  output logic                last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // State machine: idle -> convert (bit loop) -> emit (digit loop)
  bdau_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Shifter, BCD register, counters and output registers
  bdau_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last       (last)
  );

  // A digit only comes out of a word that was in progress in the previous cycle
  `BDAU_ASSERT_SAME(a_strobe_from_busy, strobe, $past(busy), "digit strobe without a word in progress")
  // Once the first digit is out, the rest follow without gaps
  `BDAU_ASSERT_NEXT(a_no_gap, strobe && !last, strobe, "gap inside a digit run")
  // The final digit closes the run
  `BDAU_ASSERT_NEXT(a_run_closed, strobe && last, !strobe, "digit after the final digit")
  // An accepted word makes the unit busy
  `BDAU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

endmodule
